### design/rsnp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RSN element parser package
// Shared codes, the queue entry type and defaults for the tagged-parameter
// parser with inline RSN decoding.
// ----------------------------------------------------------------------------
package rsnp_pkg;

    // Result kinds
    localparam logic [2:0] KIND_ELEMENT  = 3'd0;
    localparam logic [2:0] KIND_VERSION  = 3'd1;
    localparam logic [2:0] KIND_GROUP    = 3'd2;
    localparam logic [2:0] KIND_PAIRWISE = 3'd3;
    localparam logic [2:0] KIND_AKM      = 3'd4;
    localparam logic [2:0] KIND_CAPS     = 3'd5;
    localparam logic [2:0] KIND_END      = 3'd6;

    // Element framing phases
    localparam logic [1:0] PH_ID  = 2'd0;
    localparam logic [1:0] PH_LEN = 2'd1;
    localparam logic [1:0] PH_VAL = 2'd2;

    // RSN field decoder states
    localparam logic [2:0] RS_VERSION = 3'd0;
    localparam logic [2:0] RS_GROUP   = 3'd1;
    localparam logic [2:0] RS_PCOUNT  = 3'd2;
    localparam logic [2:0] RS_PAIR    = 3'd3;
    localparam logic [2:0] RS_ACOUNT  = 3'd4;
    localparam logic [2:0] RS_AKM     = 3'd5;
    localparam logic [2:0] RS_CAPS    = 3'd6;
    localparam logic [2:0] RS_DONE    = 3'd7;

    // RSN verdicts
    localparam logic [1:0] V_VALID = 2'd0;
    localparam logic [1:0] V_NONE  = 2'd1;
    localparam logic [1:0] V_BAD   = 2'd2;

    localparam logic [7:0] RSN_ID_RESET = 8'd48;

    localparam int unsigned QUEUE_DEPTH = 4;

    // Everything one input byte produces, in delivery order.
    typedef struct packed {
        logic        fld_valid;
        logic [2:0]  fld_kind;
        logic [31:0] fld_value;
        logic        elem_valid;
        logic [7:0]  elem_id;
        logic [7:0]  elem_len;
        logic        end_valid;
        logic [1:0]  end_status;
    } rsnp_bundle_t;

endpackage
`default_nettype wire

### design/rsnp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RSN parser front end
// Accepts region bytes, tracks element framing, decodes the first RSN element
// and hands every byte's results to the queue as one bundle.
// ----------------------------------------------------------------------------
module rsnp_front
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [7:0]            cfg_wdata,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [7:0]            data_byte,
    input  wire logic                  last_byte,
    input  wire logic                  q_full,
    output logic                       q_push,
    output rsnp_pkg::rsnp_bundle_t     q_data
);
    import rsnp_pkg::*;

    logic [7:0]  rsn_id_reg;
    logic [1:0]  phase_reg, phase_next;
    logic [7:0]  id_reg, id_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  left_reg, left_next;
    logic        in_rsn_reg, in_rsn_next;
    logic        seen_reg, seen_next;
    logic [2:0]  rstate_reg, rstate_next;
    logic [31:0] acc_reg, acc_next;
    logic [1:0]  bidx_reg, bidx_next;
    logic [15:0] suites_reg, suites_next;
    logic [7:0]  rleft_reg, rleft_next;
    logic [1:0]  verdict_reg, verdict_next;

    logic        accept;
    logic [31:0] acc_new;
    logic        size4;
    logic        field_done;
    logic [7:0]  left_base;
    logic [7:0]  left_after;
    logic        need_over;
    logic [7:0]  group_left;
    rsnp_bundle_t bundle;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    assign acc_new    = acc_reg | ({24'd0, data_byte} << {bidx_reg, 3'b000});
    assign size4      = (rstate_reg == RS_GROUP) || (rstate_reg == RS_PAIR) ||
                        (rstate_reg == RS_AKM);
    assign field_done = size4 ? (bidx_reg == 2'd3) : (bidx_reg != 2'd0);
    // The AKM count consumes its own two bytes before the suite budget is checked.
    assign left_base  = (rstate_reg == RS_ACOUNT) ? (rleft_reg - 8'd2) : rleft_reg;
    assign need_over  = (acc_new[15:6] != 10'd0) || ({acc_new[5:0], 2'b00} > left_base);
    assign left_after = left_base - {acc_new[5:0], 2'b00};
    assign group_left = len_reg - 8'd8;

    always_comb
    begin
        phase_next   = phase_reg;
        id_next      = id_reg;
        len_next     = len_reg;
        left_next    = left_reg;
        in_rsn_next  = in_rsn_reg;
        seen_next    = seen_reg;
        rstate_next  = rstate_reg;
        acc_next     = acc_reg;
        bidx_next    = bidx_reg;
        suites_next  = suites_reg;
        rleft_next   = rleft_reg;
        verdict_next = verdict_reg;

        bundle            = '0;
        bundle.fld_value  = acc_new;
        bundle.fld_kind   = KIND_VERSION;

        unique case (phase_reg)
            PH_LEN:
            begin
                len_next  = data_byte;
                left_next = data_byte;
                if (id_reg == rsn_id_reg && !seen_reg)
                begin
                    seen_next   = 1'b1;
                    in_rsn_next = 1'b1;
                    rstate_next = RS_VERSION;
                    acc_next    = '0;
                    bidx_next   = '0;
                    suites_next = '0;
                    rleft_next  = '0;
                    if (data_byte < 8'd8)
                    begin
                        verdict_next = V_BAD;
                        rstate_next  = RS_DONE;
                    end
                end
                if (data_byte == 8'd0)
                begin
                    bundle.elem_valid = 1'b1;
                    in_rsn_next       = 1'b0;
                    phase_next        = PH_ID;
                end
                else
                begin
                    phase_next = PH_VAL;
                end
            end
            PH_VAL:
            begin
                if (in_rsn_reg && rstate_reg != RS_DONE)
                begin
                    if (!field_done)
                    begin
                        acc_next  = acc_new;
                        bidx_next = bidx_reg + 2'd1;
                    end
                    else
                    begin
                        acc_next  = '0;
                        bidx_next = '0;
                        unique case (rstate_reg) inside
                            RS_VERSION:
                            begin
                                bundle.fld_valid = 1'b1;
                                bundle.fld_kind  = KIND_VERSION;
                                rstate_next      = RS_GROUP;
                            end
                            RS_GROUP:
                            begin
                                bundle.fld_valid = 1'b1;
                                bundle.fld_kind  = KIND_GROUP;
                                rleft_next       = group_left;
                                if (group_left < 8'd2)
                                begin
                                    verdict_next = V_BAD;
                                    rstate_next  = RS_DONE;
                                end
                                else
                                begin
                                    rstate_next = RS_PCOUNT;
                                end
                            end
                            RS_PCOUNT, RS_ACOUNT:
                            begin
                                if (need_over)
                                begin
                                    verdict_next = V_BAD;
                                    rstate_next  = RS_DONE;
                                end
                                else
                                begin
                                    rleft_next  = left_after;
                                    suites_next = acc_new[15:0];
                                    if (acc_new[15:0] != 16'd0)
                                    begin
                                        rstate_next = (rstate_reg == RS_PCOUNT) ? RS_PAIR
                                                                                : RS_AKM;
                                    end
                                    else if (left_after < 8'd2)
                                    begin
                                        verdict_next = V_BAD;
                                        rstate_next  = RS_DONE;
                                    end
                                    else
                                    begin
                                        rstate_next = (rstate_reg == RS_PCOUNT) ? RS_ACOUNT
                                                                                : RS_CAPS;
                                    end
                                end
                            end
                            RS_PAIR, RS_AKM:
                            begin
                                bundle.fld_valid = 1'b1;
                                bundle.fld_kind  = (rstate_reg == RS_PAIR) ? KIND_PAIRWISE
                                                                           : KIND_AKM;
                                suites_next      = suites_reg - 16'd1;
                                if (suites_reg == 16'd1)
                                begin
                                    if (rleft_reg < 8'd2)
                                    begin
                                        verdict_next = V_BAD;
                                        rstate_next  = RS_DONE;
                                    end
                                    else
                                    begin
                                        rstate_next = (rstate_reg == RS_PAIR) ? RS_ACOUNT
                                                                              : RS_CAPS;
                                    end
                                end
                            end
                            default:
                            begin
                                bundle.fld_valid = 1'b1;
                                bundle.fld_kind  = KIND_CAPS;
                                verdict_next     = V_VALID;
                                rstate_next      = RS_DONE;
                            end
                        endcase
                    end
                end
                left_next = left_reg - 8'd1;
                if (left_reg == 8'd1)
                begin
                    bundle.elem_valid = 1'b1;
                    in_rsn_next       = 1'b0;
                    phase_next        = PH_ID;
                end
            end
            default:
            begin
                id_next    = data_byte;
                phase_next = PH_LEN;
            end
        endcase

        bundle.elem_id  = id_reg;
        bundle.elem_len = len_next;

        if (last_byte)
        begin
            // An RSN element still open at the end of the region is incomplete.
            bundle.end_valid  = 1'b1;
            bundle.end_status = in_rsn_next ? V_NONE : verdict_next;
            phase_next   = PH_ID;
            id_next      = '0;
            len_next     = '0;
            left_next    = '0;
            in_rsn_next  = 1'b0;
            seen_next    = 1'b0;
            rstate_next  = RS_VERSION;
            acc_next     = '0;
            bidx_next    = '0;
            suites_next  = '0;
            rleft_next   = '0;
            verdict_next = V_NONE;
        end
    end

    assign q_push = accept && (bundle.fld_valid || bundle.elem_valid || bundle.end_valid);
    assign q_data = bundle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsn_id_reg  <= RSN_ID_RESET;
            phase_reg   <= PH_ID;
            id_reg      <= '0;
            len_reg     <= '0;
            left_reg    <= '0;
            in_rsn_reg  <= 1'b0;
            seen_reg    <= 1'b0;
            rstate_reg  <= RS_VERSION;
            acc_reg     <= '0;
            bidx_reg    <= '0;
            suites_reg  <= '0;
            rleft_reg   <= '0;
            verdict_reg <= V_NONE;
        end
        else
        begin
            if (cfg_we)
            begin
                rsn_id_reg <= cfg_wdata;
            end
            if (accept)
            begin
                phase_reg   <= phase_next;
                id_reg      <= id_next;
                len_reg     <= len_next;
                left_reg    <= left_next;
                in_rsn_reg  <= in_rsn_next;
                seen_reg    <= seen_next;
                rstate_reg  <= rstate_next;
                acc_reg     <= acc_next;
                bidx_reg    <= bidx_next;
                suites_reg  <= suites_next;
                rleft_reg   <= rleft_next;
                verdict_reg <= verdict_next;
            end
        end
    end

endmodule
`default_nettype wire

### design/rsnp_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RSN parser bundle queue
// Small first-in first-out buffer of result bundles between the front end
// and the output sequencer.
// ----------------------------------------------------------------------------
module rsnp_queue
#(
    parameter int unsigned DEPTH = rsnp_pkg::QUEUE_DEPTH
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire rsnp_pkg::rsnp_bundle_t push_data,
    output logic                       full,
    input  wire logic                  pop,
    output logic                       head_valid,
    output rsnp_pkg::rsnp_bundle_t     head_data
);
    import rsnp_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    rsnp_bundle_t     mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

### design/rsnp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RSN parser output sequencer
// Unpacks each queued bundle into single results and presents them one per
// cycle while out_stall is low, through a registered output stage.
// ----------------------------------------------------------------------------
module rsnp_back
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   q_valid,
    input  wire rsnp_pkg::rsnp_bundle_t q_data,
    output logic                        q_pop,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [2:0]                  kind,
    output logic [7:0]                  element_id,
    output logic [7:0]                  element_length,
    output logic [31:0]                 field_value,
    output logic [1:0]                  rsn_status,
    output logic                        final_result
);
    import rsnp_pkg::*;

    rsnp_bundle_t cur_reg;
    logic [2:0]   pend_reg;      // bit 0 field, bit 1 element, bit 2 region end
    logic [2:0]   pend_after;
    logic [2:0]   pick;
    logic         load_out;

    logic        out_valid_reg;
    logic [2:0]  kind_reg;
    logic [7:0]  id_reg;
    logic [7:0]  len_reg;
    logic [31:0] value_reg;
    logic [1:0]  status_reg;
    logic        final_reg;

    always_comb
    begin
        if (pend_reg[0])
        begin
            pick = 3'b001;
        end
        else if (pend_reg[1])
        begin
            pick = 3'b010;
        end
        else
        begin
            pick = 3'b100;
        end
    end

    assign load_out   = (pend_reg != 3'b000) && (!out_valid_reg || !out_stall);
    assign pend_after = load_out ? (pend_reg & ~pick) : pend_reg;
    assign q_pop      = q_valid && (pend_after == 3'b000);

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_data;
        end
        if (load_out)
        begin
            kind_reg   <= KIND_END;
            id_reg     <= '0;
            len_reg    <= '0;
            value_reg  <= '0;
            status_reg <= '0;
            final_reg  <= 1'b0;
            if (pick[0])
            begin
                kind_reg  <= cur_reg.fld_kind;
                value_reg <= cur_reg.fld_value;
            end
            else if (pick[1])
            begin
                kind_reg <= KIND_ELEMENT;
                id_reg   <= cur_reg.elem_id;
                len_reg  <= cur_reg.elem_len;
            end
            else
            begin
                status_reg <= cur_reg.end_status;
                final_reg  <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 3'b000;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                pend_reg <= {q_data.end_valid, q_data.elem_valid, q_data.fld_valid};
            end
            else
            begin
                pend_reg <= pend_after;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign element_id     = id_reg;
    assign element_length = len_reg;
    assign field_value    = value_reg;
    assign rsn_status     = status_reg;
    assign final_result   = final_reg;

endmodule
`default_nettype wire

### design/wlan_info_element_rsn_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tagged-parameter parser with RSN decoding
// Splits a region of information elements into elements and decodes the
// first RSN element, closing each region with an RSN verdict.
// ----------------------------------------------------------------------------
// Channel   Handshake               Payload
// input     in_valid / in_stall     data_byte, last_byte
// output    out_valid / out_stall   kind, element_id, element_length,
//                                   field_value, rsn_status, final_result
// config    cfg_we                  cfg_wdata (RSN element id)
//
// One byte is accepted per cycle while the bundle queue has room; the front
// end finishes each byte in that cycle. A byte yields up to three results,
// which the output stage delivers at one per cycle, so the output port sets
// the sustained rate. Results pass through the queue, cur_reg and output stage.
// Reset clears all parser and queue state at once; there is no clearing pass.
// A stalled output fills the queue and then stalls the input.
// ----------------------------------------------------------------------------
module wlan_info_element_rsn_parser
#(
    parameter int unsigned QUEUE_DEPTH = rsnp_pkg::QUEUE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       kind,
    output logic [7:0]       element_id,
    output logic [7:0]       element_length,
    output logic [31:0]      field_value,
    output logic [1:0]       rsn_status,
    output logic             final_result
);
    import rsnp_pkg::*;

    rsnp_bundle_t push_data;
    rsnp_bundle_t head_data;
    logic         q_push;
    logic         q_full;
    logic         q_pop;
    logic         q_valid;

    rsnp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (push_data)
    );

    rsnp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (push_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (head_data)
    );

    rsnp_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_data         (head_data),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .element_id     (element_id),
        .element_length (element_length),
        .field_value    (field_value),
        .rsn_status     (rsn_status),
        .final_result   (final_result)
    );

`ifndef NO_ASSERTIONS
    // The closing flag travels only with the region-end result.
    a_final_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (final_result == (kind == KIND_END)))
        else $error("final_result does not match a region-end result");

    // The front end never writes into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("bundle pushed into a full queue");

    // The sequencer only takes bundles that are present.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("bundle popped from an empty queue");
`endif

endmodule
`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the tagged-parameter parser with RSN decoding
// Streams a short table of directed regions and then random regions of
// information elements through the parser. Both handshakes are throttled at
// random. Every result transaction is checked field by field against a
// testbench model of the parser, or a hand-written expectation for marked bytes.
// ----------------------------------------------------------------------------
module tb_top;
    import rsnp_pkg::*;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  id;
        logic [7:0]  len;
        logic [31:0] value;
        logic [1:0]  status;
        logic        fin;
    } ie_result_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       typed;
        ie_result_t exp;
    } stim_row_t;

    localparam int unsigned QUIET_LIMIT   = 2000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned LONG_HOLD     = 400;
    localparam int unsigned PHASE_BYTES   = 40;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = '0;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  kind;
    logic [7:0]  element_id;
    logic [7:0]  element_length;
    logic [31:0] field_value;
    logic [1:0]  rsn_status;
    logic        final_result;

    // Marks the byte on offer as carrying a hand-written expectation.
    logic        cur_typed = 1'b0;
    ie_result_t  cur_exp = '0;

    // Parser model state
    logic [7:0]  rsn_id_copy;
    logic [1:0]  frame_phase;
    logic [7:0]  cur_id;
    logic [7:0]  cur_len;
    logic [7:0]  value_left;
    logic        decoding_rsn;
    logic        rsn_seen;
    logic [2:0]  rsn_state;
    logic [31:0] field_acc;
    logic [1:0]  field_idx;
    logic [15:0] suites_pending;
    logic [7:0]  rsn_room;
    logic [1:0]  verdict;

    ie_result_t  step_results[$];
    ie_result_t  pending_results[$];
    stim_row_t   directed_rows[$];
    logic [7:0]  region_q[$];
    logic [7:0]  alt_rsn_id = 8'hDD;
    logic        gaps_on = 1'b1;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;

    wlan_info_element_rsn_parser i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .element_id     (element_id),
        .element_length (element_length),
        .field_value    (field_value),
        .rsn_status     (rsn_status),
        .final_result   (final_result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic ie_result_t make_result(input logic [2:0] k, input logic [7:0] id,
                                               input logic [7:0] len, input logic [31:0] v,
                                               input logic [1:0] st, input logic fin);
        ie_result_t r;
        r.kind   = k;
        r.id     = id;
        r.len    = len;
        r.value  = v;
        r.status = st;
        r.fin    = fin;
        return r;
    endfunction

    task report_mismatch(input string what);
        mismatches++;
        $display("%0t: mismatch: %s", $time, what);
    endtask

    task push_result(input logic [2:0] k, input logic [7:0] id, input logic [7:0] len,
                     input logic [31:0] v, input logic [1:0] st, input logic fin);
        step_results.insert(step_results.size(), make_result(k, id, len, v, st, fin));
    endtask

    task clear_parser();
        frame_phase    = PH_ID;
        cur_id         = '0;
        cur_len        = '0;
        value_left     = '0;
        decoding_rsn   = 1'b0;
        rsn_seen       = 1'b0;
        rsn_state      = RS_VERSION;
        field_acc      = '0;
        field_idx      = '0;
        suites_pending = '0;
        rsn_room       = '0;
        verdict        = V_NONE;
    endtask

    task rsn_fail();
        verdict   = V_BAD;
        rsn_state = RS_DONE;
    endtask

    // Moves on to the next count or to the capabilities only if two bytes remain.
    task check_room(input logic [2:0] next_state);
        if (rsn_room < 8'd2)
            rsn_fail();
        else
            rsn_state = next_state;
    endtask

    task close_element();
        push_result(KIND_ELEMENT, cur_id, cur_len, '0, '0, 1'b0);
        decoding_rsn = 1'b0;
        frame_phase  = PH_ID;
    endtask

    task decode_rsn_byte(input logic [7:0] b);
        int unsigned size;
        logic [31:0] v;
        logic [31:0] need;
        if (rsn_state == RS_DONE)
            return;
        size = (rsn_state == RS_GROUP || rsn_state == RS_PAIR || rsn_state == RS_AKM) ? 4 : 2;
        field_acc = field_acc | (32'(b) << (8 * field_idx));
        if (field_idx + 1 < size)
        begin
            field_idx = field_idx + 2'd1;
            return;
        end
        v         = field_acc;
        field_acc = '0;
        field_idx = '0;
        case (rsn_state)
            RS_VERSION:
            begin
                push_result(KIND_VERSION, '0, '0, v, '0, 1'b0);
                rsn_state = RS_GROUP;
            end
            RS_GROUP:
            begin
                push_result(KIND_GROUP, '0, '0, v, '0, 1'b0);
                rsn_room = cur_len - 8'd8;
                check_room(RS_PCOUNT);
            end
            RS_PCOUNT:
            begin
                need = v * 4;
                if (need > 32'(rsn_room))
                    rsn_fail();
                else
                begin
                    rsn_room       = rsn_room - need[7:0];
                    suites_pending = v[15:0];
                    if (suites_pending == 0)
                        check_room(RS_ACOUNT);
                    else
                        rsn_state = RS_PAIR;
                end
            end
            RS_PAIR:
            begin
                push_result(KIND_PAIRWISE, '0, '0, v, '0, 1'b0);
                suites_pending = suites_pending - 16'd1;
                if (suites_pending == 0)
                    check_room(RS_ACOUNT);
            end
            RS_ACOUNT:
            begin
                // The count itself uses up two of the remaining bytes.
                rsn_room = rsn_room - 8'd2;
                need     = v * 4;
                if (need > 32'(rsn_room))
                    rsn_fail();
                else
                begin
                    rsn_room       = rsn_room - need[7:0];
                    suites_pending = v[15:0];
                    if (suites_pending == 0)
                        check_room(RS_CAPS);
                    else
                        rsn_state = RS_AKM;
                end
            end
            RS_AKM:
            begin
                push_result(KIND_AKM, '0, '0, v, '0, 1'b0);
                suites_pending = suites_pending - 16'd1;
                if (suites_pending == 0)
                    check_room(RS_CAPS);
            end
            default:
            begin
                push_result(KIND_CAPS, '0, '0, v, '0, 1'b0);
                verdict   = V_VALID;
                rsn_state = RS_DONE;
            end
        endcase
    endtask

    task parse_byte(input logic [7:0] b, input logic last);
        step_results.delete();
        case (frame_phase)
            PH_LEN:
            begin
                cur_len    = b;
                value_left = b;
                if (cur_id == rsn_id_copy && !rsn_seen)
                begin
                    rsn_seen       = 1'b1;
                    decoding_rsn   = 1'b1;
                    rsn_state      = RS_VERSION;
                    field_acc      = '0;
                    field_idx      = '0;
                    suites_pending = '0;
                    rsn_room       = '0;
                    if (b < 8'd8)
                        rsn_fail();
                end
                if (b == 8'd0)
                    close_element();
                else
                    frame_phase = PH_VAL;
            end
            PH_VAL:
            begin
                if (decoding_rsn)
                    decode_rsn_byte(b);
                value_left = value_left - 8'd1;
                if (value_left == 8'd0)
                    close_element();
            end
            default:
            begin
                cur_id      = b;
                frame_phase = PH_LEN;
            end
        endcase
        if (last)
        begin
            // An RSN element cut off by the end of the region never completes.
            if (decoding_rsn)
                verdict = V_NONE;
            push_result(KIND_END, '0, '0, '0, verdict, 1'b1);
            clear_parser();
        end
    endtask

    always @(posedge clk)
    begin : result_check
        ie_result_t got;
        ie_result_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                parse_byte(data_byte, last_byte);
                if (cur_typed)
                    pending_results.insert(pending_results.size(), cur_exp);
                else
                    foreach (step_results[i])
                        pending_results.insert(pending_results.size(), step_results[i]);
            end
            if (out_valid && !out_stall)
            begin
                got = make_result(kind, element_id, element_length, field_value, rsn_status,
                                  final_result);
                if (pending_results.size() == 0)
                    report_mismatch($sformatf("unexpected result %p", got));
                else
                begin
                    want = pending_results[0];
                    pending_results.delete(0);
                    if (got.kind != want.kind)
                        report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
                    if (got.id != want.id)
                        report_mismatch($sformatf("element_id %0h, expected %0h",
                                                  got.id, want.id));
                    if (got.len != want.len)
                        report_mismatch($sformatf("element_length %0d, expected %0d",
                                                  got.len, want.len));
                    if (got.value != want.value)
                        report_mismatch($sformatf("field_value %0h, expected %0h",
                                                  got.value, want.value));
                    if (got.status != want.status)
                        report_mismatch($sformatf("rsn_status %0d, expected %0d",
                                                  got.status, want.status));
                    if (got.fin != want.fin)
                        report_mismatch($sformatf("final_result %0b, expected %0b",
                                                  got.fin, want.fin));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side: a random hold-off before each transaction, once a long one.
    initial
    begin : result_sink
        int unsigned hold;
        int unsigned seen;
        logic        long_done;
        logic        stalls_on;
        seen      = 0;
        long_done = 1'b0;
        stalls_on = 1'b1;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (seen % 32 == 0)
                stalls_on = ($urandom_range(0, 2) != 0);
            hold = stalls_on ? $urandom_range(0, 12) : 0;
            if (!long_done && seen >= 20)
            begin
                hold      = LONG_HOLD;
                long_done = 1'b1;
            end
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
            seen++;
            @(negedge clk);
        end
    end

    task send_byte(input logic [7:0] b, input logic last, input logic typed,
                   input ie_result_t exp);
        int unsigned gap;
        gap = gaps_on ? $urandom_range(0, 12) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= last;
        cur_typed <= typed;
        cur_exp   <= exp;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // Lets every expected result out and the pipeline settle.
    task wait_drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task write_rsn_id(input logic [7:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we      <= 1'b0;
        rsn_id_copy = v;
    endtask

    task add_row(input logic [7:0] b, input logic last, input logic typed, input ie_result_t exp);
        stim_row_t row;
        row.data  = b;
        row.last  = last;
        row.typed = typed;
        row.exp   = exp;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    // A mostly well-formed RSN element with random suites; some are damaged.
    task append_rsn(input logic [7:0] id);
        logic [7:0]  body[$];
        int unsigned npair;
        int unsigned nakm;
        int unsigned flavour;
        int unsigned blen;
        logic [15:0] pcount;
        logic [15:0] acount;
        npair   = $urandom_range(0, 3);
        nakm    = $urandom_range(0, 3);
        flavour = $urandom_range(0, 9);
        pcount  = 16'(npair);
        acount  = 16'(nakm);
        if (flavour == 0)
            pcount = 16'($urandom);
        if (flavour == 1)
            acount = acount + 16'($urandom_range(1, 2));
        body.insert(body.size(), ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h01);
        body.insert(body.size(), ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00);
        repeat (4) body.insert(body.size(), 8'($urandom));
        body.insert(body.size(), pcount[7:0]);
        body.insert(body.size(), pcount[15:8]);
        repeat (4 * npair) body.insert(body.size(), 8'($urandom));
        body.insert(body.size(), acount[7:0]);
        body.insert(body.size(), acount[15:8]);
        repeat (4 * nakm) body.insert(body.size(), 8'($urandom));
        repeat (2 + $urandom_range(0, 3)) body.insert(body.size(), 8'($urandom));
        blen = body.size();
        if (flavour == 2)
            blen = $urandom_range(0, body.size() - 1);
        if (flavour == 3)
            blen = $urandom_range(8, body.size());
        region_q.insert(region_q.size(), id);
        region_q.insert(region_q.size(), 8'(blen));
        for (int i = 0; i < blen; i++)
            region_q.insert(region_q.size(), body[i]);
    endtask

    task append_other();
        int unsigned len;
        len = ($urandom_range(0, 49) == 0) ? 255 : $urandom_range(0, 6);
        region_q.insert(region_q.size(), 8'($urandom));
        region_q.insert(region_q.size(), 8'(len));
        repeat (len) region_q.insert(region_q.size(), 8'($urandom));
    endtask

    task build_region();
        int unsigned ending;
        int unsigned keep;
        region_q.delete();
        repeat ($urandom_range(1, 4))
        begin
            if ($urandom_range(0, 1) != 0)
                append_rsn(($urandom_range(0, 1) != 0) ? rsn_id_copy : alt_rsn_id);
            else
                append_other();
        end
        ending = $urandom_range(0, 9);
        if (ending >= 6 && ending < 8)
        begin
            // Cut the region short anywhere, often inside an element.
            keep = $urandom_range(1, region_q.size() - 1);
            while (region_q.size() > keep)
                void'(region_q.pop_back());
        end
        else if (ending >= 8)
            region_q.insert(region_q.size(), 8'($urandom));
    endtask

    initial
    begin : stimulus
        logic [7:0]  plan[4];
        int unsigned sent;
        logic        split;
        ie_result_t  unchecked;
        unchecked   = '0;
        rsn_id_copy = RSN_ID_RESET;
        clear_parser();
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        write_rsn_id(RSN_ID_RESET);

        // A lone id byte at the end of a region.
        add_row(8'hAB, 1'b1, 1'b1, make_result(KIND_END, '0, '0, '0, V_NONE, 1'b1));
        // Empty element, then a truncated one.
        add_row(8'hFF, 1'b0, 1'b0, unchecked);
        add_row(8'h00, 1'b0, 1'b1, make_result(KIND_ELEMENT, 8'hFF, 8'h00, '0, '0, 1'b0));
        add_row(8'h00, 1'b0, 1'b0, unchecked);
        add_row(8'h05, 1'b0, 1'b0, unchecked);
        add_row(8'h11, 1'b0, 1'b0, unchecked);
        add_row(8'h22, 1'b1, 1'b1, make_result(KIND_END, '0, '0, '0, V_NONE, 1'b1));
        // Shortest valid RSN: no pairwise or AKM suites.
        add_row(RSN_ID_RESET, 1'b0, 1'b0, unchecked);
        add_row(8'h0C, 1'b0, 1'b0, unchecked);
        add_row(8'h01, 1'b0, 1'b0, unchecked);
        add_row(8'h00, 1'b0, 1'b1, make_result(KIND_VERSION, '0, '0, 32'd1, '0, 1'b0));
        add_row(8'h00, 1'b0, 1'b0, unchecked);
        add_row(8'h0F, 1'b0, 1'b0, unchecked);
        add_row(8'hAC, 1'b0, 1'b0, unchecked);
        add_row(8'h04, 1'b0, 1'b0, unchecked);
        repeat (4) add_row(8'h00, 1'b0, 1'b0, unchecked);
        add_row(8'hFF, 1'b0, 1'b0, unchecked);
        add_row(8'hFF, 1'b1, 1'b0, unchecked);
        // RSN element too short to hold the group suite.
        add_row(RSN_ID_RESET, 1'b0, 1'b0, unchecked);
        add_row(8'h03, 1'b0, 1'b0, unchecked);
        add_row(8'hAA, 1'b0, 1'b0, unchecked);
        add_row(8'hBB, 1'b0, 1'b0, unchecked);
        add_row(8'hCC, 1'b1, 1'b0, unchecked);

        foreach (directed_rows[i])
            send_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].typed,
                      directed_rows[i].exp);

        plan[0] = 8'hFF;
        plan[1] = 8'h00;
        plan[2] = 8'($urandom);
        plan[3] = RSN_ID_RESET;
        for (int p = 0; p < 4; p++)
        begin
            wait_drain();
            write_rsn_id(plan[p]);
            alt_rsn_id = 8'($urandom);
            sent       = 0;
            split      = (p == 3);
            while (sent < PHASE_BYTES)
            begin
                build_region();
                gaps_on = ($urandom_range(0, 2) != 0);
                foreach (region_q[i])
                begin
                    // Change the RSN id half way through a region while it is idle.
                    if (split && i == region_q.size() / 2)
                    begin
                        wait_drain();
                        write_rsn_id(alt_rsn_id);
                        split = 1'b0;
                    end
                    send_byte(region_q[i], i == region_q.size() - 1, 1'b0, unchecked);
                end
                sent += region_q.size();
            end
        end

        wait_drain();
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
